### rtl/core/cmpcal_pkg.sv
// Shared constants, types and the arctangent table of the compass heading block.
package cmpcal_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_FRAC_BITS   = 7;

  // The quotient of a normalisation has 32 bits, one found per step.
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2((DIV_STEPS > CORDIC_ITERATIONS) ?
                                    DIV_STEPS : CORDIC_ITERATIONS);

  localparam int Q_W  = 18;  // normalised axis value, Q2.16
  localparam int CV_W = 29;  // CORDIC vector components
  localparam int Z_W  = 26;  // CORDIC angle, degrees * 2^16

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int H_W       = $clog2(FULL_TURN) + 2;

  localparam logic [1:0] OP_HEADING = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_CALIB   = 2'd2;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_RESTART = 2'd1;
  localparam logic [1:0] ST_UPDATE  = 2'd2;
  localparam logic [1:0] ST_DEGEN   = 2'd3;

  localparam logic [1:0] ORI_YZ = 2'd0;
  localparam logic [1:0] ORI_XZ = 2'd1;
  localparam logic [1:0] ORI_XY = 2'd2;

  typedef struct packed {
    logic             take;
    logic             chk;
    logic             div_step;
    logic             norm;
    logic             rot;
    logic             iter;
    logic             wrap;
    logic             ref_sub;
    logic             out_load;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_cal;
    logic degen;
  } sts_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [CNT_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117305);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/cmpcal_if.sv
// Valid/ready channel interfaces for magnetometer samples and heading results.
interface cmpcal_mag_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source (output valid, operation, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, operation, mag_x, mag_y, mag_z, output ready);
endinterface

interface cmpcal_hdg_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  logic [1:0]  status;

  modport source (output valid, heading, status, input ready);
  modport sink   (input valid, heading, status, output ready);
endinterface

### rtl/core/compass_heading_minmax_cal.sv
// Top level of the min/max calibrated magnetometer compass heading block.
//
// Samples arrive on the mag_i channel (valid/ready); one result per sample
// leaves on the hdg_o channel. A transfer is taken only while the block is
// idle. A calibration restart or calibration sample passes through the
// range check, the output load and the idle state. A heading sample passes
// through a range check, two normalisation dividers side by side at one
// quotient bit per cycle, saturation, the half-plane fold, one CORDIC
// iteration per cycle, wrap, reference subtraction, output load and the
// idle state. A degenerate axis range is answered like a calibration item.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and processed, and it then waits until the earlier
// result has been transferred. Reset restores the calibration to minimum 0,
// maximum 1 on every axis, orientation to atan2(x,y) and the reference to 0.
// Registers are written over the APB port: orientation at 0, reference at 4.
// The user must write them only while no sample is in flight; the block
// itself does not enforce this.
module compass_heading_minmax_cal
  import cmpcal_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cmpcal_mag_if.sink    mag_i,
  cmpcal_hdg_if.source  hdg_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [1:0]  orientation_q;
  logic [15:0] reference_q;
  logic        wr_en;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orientation_q <= ORI_XY;
      reference_q   <= 16'd0;
    end else if (wr_en) begin
      if (paddr[2]) begin
        reference_q <= pwdata[15:0];
      end else begin
        orientation_q <= pwdata[1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'b0, reference_q} : {30'b0, orientation_q};

  cmpcal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mag_i.valid),
    .in_ready_o  (mag_i.ready),
    .out_ready_i (hdg_o.ready),
    .out_valid_o (hdg_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cmpcal_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (mag_i.operation),
    .mag_x_i       (mag_i.mag_x),
    .mag_y_i       (mag_i.mag_y),
    .mag_z_i       (mag_i.mag_z),
    .orientation_i (orientation_q),
    .reference_i   (reference_q),
    .heading_o     (hdg_o.heading),
    .status_o      (hdg_o.status)
  );

endmodule

### rtl/core/cmpcal_ctrl.sv
// Controller state machine sequencing calibration, division, CORDIC and result transfer.
module cmpcal_ctrl
  import cmpcal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_ITER = 4'd5;
  localparam logic [3:0] S_WRAP = 4'd6;
  localparam logic [3:0] S_REF  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        cnt_d     = '0;
        if (sts_i.is_cal || sts_i.degen) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        cnt_d     = '0;
        state_d   = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = S_REF;
      end
      S_REF: begin
        cmd_o.ref_sub = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // Wait here only while an earlier result is still unclaimed.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

### rtl/core/cmpcal_dp.sv
// Datapath: calibration extremes, two serial dividers, CORDIC unit and heading wrap.
module cmpcal_dp
  import cmpcal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  input  logic [1:0]         orientation_i,
  input  logic [15:0]        reference_i,
  output logic [15:0]        heading_o,
  output logic [1:0]         status_o
);

  logic signed [15:0] min_x_q, min_y_q, min_z_q;
  logic signed [15:0] max_x_q, max_y_q, max_z_q;

  logic [1:0]         op_q;
  logic signed [15:0] va_q, vb_q, mina_q, minb_q;
  logic signed [16:0] rga_q, rgb_q;
  logic [1:0]         st_q;

  logic [31:0]        dvd_a_q, dvd_b_q;
  logic [15:0]        rem_a_q, rem_b_q;
  logic [15:0]        dvs_a_q, dvs_b_q;
  logic               neg_a_q, neg_b_q;

  logic signed [Q_W-1:0]  qa_q, qb_q;
  logic signed [CV_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic                   zero_q;
  logic signed [H_W-1:0]  h_q;
  logic [15:0]            res_q;
  logic [15:0]            heading_q;
  logic [1:0]             status_q;

  logic signed [15:0] sa, sb, smina, sminb, smaxa, smaxb;
  logic               is_cal;

  always_comb begin
    case (orientation_i)
      ORI_YZ: begin
        sa = mag_y_i; smina = min_y_q; smaxa = max_y_q;
        sb = mag_z_i; sminb = min_z_q; smaxb = max_z_q;
      end
      ORI_XZ: begin
        sa = mag_x_i; smina = min_x_q; smaxa = max_x_q;
        sb = mag_z_i; sminb = min_z_q; smaxb = max_z_q;
      end
      default: begin
        sa = mag_x_i; smina = min_x_q; smaxa = max_x_q;
        sb = mag_y_i; sminb = min_y_q; smaxb = max_y_q;
      end
    endcase
  end

  assign is_cal       = (op_q == OP_RESTART) || (op_q == OP_CALIB);
  assign sts_o.is_cal = is_cal;
  assign sts_o.degen  = (rga_q <= 0) || (rgb_q <= 0);

  // Calibration extremes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= 16'sd0; min_y_q <= 16'sd0; min_z_q <= 16'sd0;
      max_x_q <= 16'sd1; max_y_q <= 16'sd1; max_z_q <= 16'sd1;
    end else if (cmd_i.take && operation_i == OP_RESTART) begin
      min_x_q <= 16'sh7fff; min_y_q <= 16'sh7fff; min_z_q <= 16'sh7fff;
      max_x_q <= 16'sh8000; max_y_q <= 16'sh8000; max_z_q <= 16'sh8000;
    end else if (cmd_i.take && operation_i == OP_CALIB) begin
      if (mag_x_i < min_x_q) min_x_q <= mag_x_i;
      if (mag_y_i < min_y_q) min_y_q <= mag_y_i;
      if (mag_z_i < min_z_q) min_z_q <= mag_z_i;
      if (mag_x_i > max_x_q) max_x_q <= mag_x_i;
      if (mag_y_i > max_y_q) max_y_q <= mag_y_i;
      if (mag_z_i > max_z_q) max_z_q <= mag_z_i;
    end
  end

  // Normalisation numerators and their magnitudes.
  logic signed [16:0] num_a, num_b;
  logic [15:0]        abs_a, abs_b;

  assign num_a = 17'(va_q) - 17'(mina_q);
  assign num_b = 17'(vb_q) - 17'(minb_q);
  assign abs_a = num_a[16] ? 16'(-num_a) : num_a[15:0];
  assign abs_b = num_b[16] ? 16'(-num_b) : num_b[15:0];

  // One restoring division step: the dividend register fills with quotient bits.
  logic [16:0] r_a, r_b;
  logic        ge_a, ge_b;

  assign r_a  = {rem_a_q, dvd_a_q[31]};
  assign r_b  = {rem_b_q, dvd_b_q[31]};
  assign ge_a = r_a >= {1'b0, dvs_a_q};
  assign ge_b = r_b >= {1'b0, dvs_b_q};

  function automatic logic signed [Q_W-1:0] sat_q(input logic [31:0] mag, input logic neg);
    logic signed [33:0] sm;
    logic signed [33:0] q;
    logic signed [Q_W-1:0] r;
    sm = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    q  = sm - 34'sd32768;
    if (q > 34'sd131071) begin
      r = Q_W'(131071);
    end else if (q < -34'sd131072) begin
      r = Q_W'(-131072);
    end else begin
      r = q[Q_W-1:0];
    end
    return r;
  endfunction

  // CORDIC operands.
  logic signed [CV_W-1:0] x0, y0, dx, dy;

  assign x0 = {{(CV_W-Q_W-8){qb_q[Q_W-1]}}, qb_q, 8'b0};
  assign y0 = {{(CV_W-Q_W-8){qa_q[Q_W-1]}}, qa_q, 8'b0};
  assign dx = y_q >>> cmd_i.step;
  assign dy = x_q >>> cmd_i.step;

  // Final rounding of the angle and wrap to one turn.
  logic signed [Z_W-1:0] z_rnd;
  logic signed [H_W-1:0] h_raw, h_ref, refm, h_sub;

  assign z_rnd = (z_q + Z_W'(1 << (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
  assign h_raw = z_rnd[H_W-1:0];
  assign h_ref = $signed({{(H_W-16){1'b0}}, reference_i});
  assign refm  = (h_ref >= H_W'(FULL_TURN)) ? h_ref - H_W'(FULL_TURN) : h_ref;
  assign h_sub = h_q - refm;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q   <= operation_i;
      va_q   <= sa;
      vb_q   <= sb;
      mina_q <= smina;
      minb_q <= sminb;
      rga_q  <= 17'(smaxa) - 17'(smina);
      rgb_q  <= 17'(smaxb) - 17'(sminb);
    end
    if (cmd_i.chk) begin
      dvd_a_q <= {abs_a, 16'b0};
      dvd_b_q <= {abs_b, 16'b0};
      rem_a_q <= '0;
      rem_b_q <= '0;
      dvs_a_q <= rga_q[15:0];
      dvs_b_q <= rgb_q[15:0];
      neg_a_q <= num_a[16];
      neg_b_q <= num_b[16];
      if (is_cal) begin
        st_q <= (op_q == OP_RESTART) ? ST_RESTART : ST_UPDATE;
      end else if (sts_o.degen) begin
        st_q <= ST_DEGEN;
      end else begin
        st_q <= ST_VALID;
      end
    end
    if (cmd_i.div_step) begin
      rem_a_q <= ge_a ? 16'(r_a - {1'b0, dvs_a_q}) : r_a[15:0];
      rem_b_q <= ge_b ? 16'(r_b - {1'b0, dvs_b_q}) : r_b[15:0];
      dvd_a_q <= {dvd_a_q[30:0], ge_a};
      dvd_b_q <= {dvd_b_q[30:0], ge_b};
    end
    if (cmd_i.norm) begin
      qa_q <= sat_q(dvd_a_q, neg_a_q);
      qb_q <= sat_q(dvd_b_q, neg_b_q);
    end
    if (cmd_i.rot) begin
      zero_q <= (qa_q == '0) && (qb_q == '0);
      // Vectors in the left half plane are turned by a quarter turn first.
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_q <= y0;
          y_q <= -x0;
          z_q <= Z_W'(90 * 65536);
        end else begin
          x_q <= -y0;
          y_q <= x0;
          z_q <= Z_W'(-90 * 65536);
        end
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end
    if (cmd_i.iter) begin
      if (zero_q) begin
        z_q <= '0;
      end else if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_lut(cmd_i.step);
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_lut(cmd_i.step);
      end
    end
    if (cmd_i.wrap) begin
      if (h_raw < 0) begin
        h_q <= h_raw + H_W'(FULL_TURN);
      end else if (h_raw >= H_W'(FULL_TURN)) begin
        h_q <= h_raw - H_W'(FULL_TURN);
      end else begin
        h_q <= h_raw;
      end
    end
    if (cmd_i.ref_sub) begin
      res_q <= (h_sub < 0) ? 16'(h_sub + H_W'(FULL_TURN)) : h_sub[15:0];
    end
    if (cmd_i.out_load) begin
      heading_q <= (st_q == ST_VALID) ? res_q : 16'd0;
      status_q  <= st_q;
    end
  end

  assign heading_o = heading_q;
  assign status_o  = status_q;

endmodule
